>>> rtl/buzzer_tone_sequencer_macros.svh
// Assertion macros used by the buzzer tone sequencer checker.
`ifndef BUZZER_TONE_SEQUENCER_MACROS_SVH
`define BUZZER_TONE_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bts assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bts assertion failed");

`endif

>>> rtl/bts_pkg.sv
// Types, codes and the beep step table of the buzzer tone sequencer.
package bts_pkg;

  typedef enum logic [1:0] {
    CmdTick = 2'd0,
    CmdPlay = 2'd1,
    CmdStop = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ReqButton   = 3'd0,
    ReqVictory  = 3'd1,
    ReqDot      = 3'd2,
    ReqDash     = 3'd3,
    ReqSolenoid = 3'd4
  } req_e;

  localparam logic [2:0] NumSeqs = 3'd5;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhTone = 3'b010,
    PhGap  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] request_code;
  } in_item_t;

  typedef struct packed {
    logic        tone_on;
    logic [11:0] tone_frequency;
    logic        request_accepted;
    logic        playing;
  } out_item_t;

  typedef struct packed {
    logic [11:0] freq;
    logic [8:0]  dur;
    logic [8:0]  gap;
  } step_t;

  function automatic logic [3:0] seq_len(input logic [2:0] seq);
    logic [3:0] n;
    case (seq)
      ReqButton:   n = 4'd1;
      ReqVictory:  n = 4'd6;
      ReqDot:      n = 4'd1;
      ReqDash:     n = 4'd1;
      ReqSolenoid: n = 4'd8;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic step_t step_lookup(input logic [2:0] seq, input logic [2:0] idx);
    step_t st;
    st = '0;
    case (seq)
      ReqButton: begin
        if (idx == 3'd0) st = '{12'd2200, 9'd35, 9'd0};
      end
      ReqVictory: begin
        case (idx)
          3'd0:    st = '{12'd988, 9'd110, 9'd35};
          3'd1:    st = '{12'd1319, 9'd110, 9'd35};
          3'd2:    st = '{12'd1568, 9'd130, 9'd45};
          3'd3:    st = '{12'd1976, 9'd180, 9'd60};
          3'd4:    st = '{12'd1568, 9'd100, 9'd35};
          3'd5:    st = '{12'd1976, 9'd260, 9'd0};
          default: st = '0;
        endcase
      end
      ReqDot: begin
        if (idx == 3'd0) st = '{12'd900, 9'd120, 9'd0};
      end
      ReqDash: begin
        if (idx == 3'd0) st = '{12'd900, 9'd360, 9'd0};
      end
      ReqSolenoid: begin
        st = '{12'd1250, 9'd120, (idx == 3'd7) ? 9'd0 : 9'd90};
      end
      default: st = '0;
    endcase
    return st;
  endfunction

endpackage

>>> rtl/buzzer_tone_sequencer.sv
// Buzzer tone sequencer top level: step table playback with one result per item.
//
// Plays one of five canned beep sequences (button, victory, dot, dash,
// solenoid) from a built-in step table. Each input transfer is a 1 ms tick,
// a play request or a stop; each one yields exactly one result transfer with
// the tone state after the item, plus request_accepted for known play codes.
// The block takes one item per cycle: the sequencer state and the result
// register update on the same edge as the input transfer, so a result shows
// on out_data_o in the cycle after its item. in_ready_o is high whenever the
// result register is empty or its result is being taken in that cycle, so
// throughput is set by the single output register and the consumer's ready.
// While cfg enable is 0, ticks and play requests leave the state frozen;
// stop always returns to idle. Sequences are cut to MAX_SEQ_STEPS steps.
module buzzer_tone_sequencer
  import bts_pkg::*;
#(
  parameter int MAX_SEQ_STEPS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [3:0] MaxSteps = 4'(MAX_SEQ_STEPS);

  // Sequencer state
  logic       enable_q;
  logic [2:0] seq_q, seq_d;
  logic [3:0] idx_q, idx_d;
  logic [3:0] cnt_q, cnt_d;
  phase_e     phase_q, phase_d;
  logic [8:0] rem_q, rem_d;

  // Result register
  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  logic  in_xfer;
  step_t cur_st, nxt_st, first_st, play_st;
  logic [3:0] nxt_idx, play_len;
  logic [8:0] rem_dec;
  logic       accepted;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  assign cur_st   = step_lookup(seq_q, idx_q[2:0]);
  assign nxt_idx  = idx_q + 4'd1;
  assign nxt_st   = step_lookup(seq_q, nxt_idx[2:0]);
  assign first_st = step_lookup(in_data_i.request_code, 3'd0);
  assign play_len = (seq_len(in_data_i.request_code) > MaxSteps) ? MaxSteps
                                                                  : seq_len(in_data_i.request_code);
  assign rem_dec  = (rem_q != 9'd0) ? rem_q - 9'd1 : 9'd0;

  always_comb begin
    seq_d    = seq_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    phase_d  = phase_q;
    rem_d    = rem_q;
    accepted = 1'b0;
    case (in_data_i.command)
      CmdTick: begin
        if (enable_q && phase_q != PhIdle) begin
          rem_d = rem_dec;
          if (rem_dec == 9'd0) begin
            if (phase_q == PhTone && cur_st.gap != 9'd0) begin
              phase_d = PhGap;
              rem_d   = cur_st.gap;
            end else if (nxt_idx >= cnt_q || nxt_idx[3]) begin
              // past the last step
              phase_d = PhIdle;
              idx_d   = 4'd0;
              cnt_d   = 4'd0;
              rem_d   = 9'd0;
            end else begin
              idx_d = nxt_idx;
              if (nxt_st.freq == 12'd0 || nxt_st.dur == 9'd0) begin
                phase_d = PhGap;
                rem_d   = nxt_st.gap;
              end else begin
                phase_d = PhTone;
                rem_d   = nxt_st.dur;
              end
            end
          end
        end
      end
      CmdPlay: begin
        if (in_data_i.request_code < NumSeqs) begin
          accepted = 1'b1;
          if (enable_q) begin
            seq_d = in_data_i.request_code;
            cnt_d = play_len;
            idx_d = 4'd0;
            if (first_st.freq == 12'd0 || first_st.dur == 9'd0) begin
              phase_d = PhGap;
              rem_d   = first_st.gap;
            end else begin
              phase_d = PhTone;
              rem_d   = first_st.dur;
            end
          end
        end
      end
      CmdStop: begin
        phase_d = PhIdle;
        idx_d   = 4'd0;
        cnt_d   = 4'd0;
        rem_d   = 9'd0;
      end
      default: begin
        // unused command code: no change
      end
    endcase
  end

  // Result reflects the state after this item
  assign play_st = step_lookup(seq_d, idx_d[2:0]);

  always_comb begin
    out_data_d.tone_on          = (phase_d == PhTone);
    out_data_d.tone_frequency   = (phase_d == PhTone) ? play_st.freq : 12'd0;
    out_data_d.request_accepted = accepted;
    out_data_d.playing          = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      seq_q       <= 3'd0;
      idx_q       <= 4'd0;
      cnt_q       <= 4'd0;
      phase_q     <= PhIdle;
      rem_q       <= 9'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        enable_q <= cfg_data_i;
      end
      if (in_xfer) begin
        seq_q   <= seq_d;
        idx_q   <= idx_d;
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
        rem_q   <= rem_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/bts_checker.sv
// Port-level assertion checker for the buzzer tone sequencer, with its bind.
`include "buzzer_tone_sequencer_macros.svh"

module bts_checker
  import bts_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  `BTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `BTS_ASSERT_NEXT(a_in_gives_out, in_valid_i && in_ready_o, out_valid_o)
  `BTS_ASSERT_IMPL(a_tone_implies_play, out_valid_o && out_data_o.tone_on, out_data_o.playing)
  `BTS_ASSERT_IMPL(a_silent_freq, out_valid_o && !out_data_o.tone_on, out_data_o.tone_frequency == 12'd0)
  `BTS_ASSERT_IMPL(a_tone_freq, out_valid_o && out_data_o.tone_on, out_data_o.tone_frequency != 12'd0)

endmodule

bind buzzer_tone_sequencer bts_checker u_bts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

>>> dv/tb.sv
// Testbench for the buzzer tone sequencer: directed, full-playback and random tests.
module tb;
  import bts_pkg::*;

  // Command value with no meaning; the block must treat it as a no-op.
  localparam logic [1:0] CmdNone    = 2'd3;
  // Highest request code the field can carry (codes from NumSeqs up are invalid).
  localparam logic [2:0] ReqCodeMax = 3'd7;
  localparam int         MaxSteps   = 8;
  localparam int         TableSteps = 8;
  // Longest sequence played to its end in the full-playback test, in ticks.
  localparam int         FullPlayMaxMs = 400;
  // Longest tick run of one random episode.
  localparam int         TickCap       = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  buzzer_tone_sequencer #(
    .MAX_SEQ_STEPS(MaxSteps)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Idle rates in percent of cycles, changed between test phases.
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;

  // Tone results the sequencer still owes, oldest first.
  out_item_t expected_tones[$];

  // ---------------------------------------------------------------------------
  // Sequencer predictor state: mirrors what the block should hold after each
  // accepted transfer. Updated from the monitor below and cleared by reset_dut.
  // ---------------------------------------------------------------------------
  logic       en_q;
  phase_e     ph;
  logic [2:0] cur_seq;
  logic [3:0] cur_idx;
  logic [3:0] cur_cnt;
  logic [8:0] ms_left;

  // Beep table: frequency in Hz, tone and gap lengths in ms.
  function automatic step_t tone_step(input logic [2:0] seq, input logic [2:0] idx);
    step_t st;
    st = '0;
    case (seq)
      ReqButton: begin
        if (idx == 0) st = {12'd2200, 9'd35, 9'd0};
      end
      ReqVictory: begin
        case (idx)
          3'd0: st = {12'd988, 9'd110, 9'd35};
          3'd1: st = {12'd1319, 9'd110, 9'd35};
          3'd2: st = {12'd1568, 9'd130, 9'd45};
          3'd3: st = {12'd1976, 9'd180, 9'd60};
          3'd4: st = {12'd1568, 9'd100, 9'd35};
          3'd5: st = {12'd1976, 9'd260, 9'd0};
          default: st = '0;
        endcase
      end
      ReqDot: begin
        if (idx == 0) st = {12'd900, 9'd120, 9'd0};
      end
      ReqDash: begin
        if (idx == 0) st = {12'd900, 9'd360, 9'd0};
      end
      ReqSolenoid: begin
        // Eight identical clicks, the last one without a trailing gap.
        st = {12'd1250, 9'd120, (idx == 3'd7) ? 9'd0 : 9'd90};
      end
      default: st = '0;
    endcase
    return st;
  endfunction

  function automatic logic [3:0] seq_steps(input logic [2:0] seq);
    case (seq)
      ReqButton:   return 4'd1;
      ReqVictory:  return 4'd6;
      ReqDot:      return 4'd1;
      ReqDash:     return 4'd1;
      ReqSolenoid: return 4'd8;
      default:     return 4'd0;
    endcase
  endfunction

  // Whole playing time of a sequence in ticks; 0 for an unknown code.
  function automatic int seq_total_ms(input logic [2:0] seq);
    int total;
    int n;
    step_t st;
    total = 0;
    n = int'(seq_steps(seq));
    if (n > MaxSteps) n = MaxSteps;
    for (int i = 0; i < n; i++) begin
      st = tone_step(seq, i[2:0]);
      total += st.dur + st.gap;
    end
    return total;
  endfunction

  function automatic void halt_playback();
    ph = PhIdle;
    cur_idx = '0;
    cur_cnt = '0;
    ms_left = '0;
  endfunction

  function automatic void reset_model();
    en_q = 1'b0;
    cur_seq = '0;
    halt_playback();
  endfunction

  // Load the current step: silent steps go straight to their gap.
  function automatic void enter_step();
    step_t st;
    if (ph == PhIdle || cur_idx >= cur_cnt || cur_idx >= TableSteps) begin
      halt_playback();
      return;
    end
    st = tone_step(cur_seq, cur_idx[2:0]);
    if (st.freq == 0 || st.dur == 0) begin
      ph = PhGap;
      ms_left = st.gap;
    end else begin
      ph = PhTone;
      ms_left = st.dur;
    end
  endfunction

  function automatic void advance_step();
    cur_idx = cur_idx + 4'd1;
    if (cur_idx >= cur_cnt) begin
      halt_playback();
      return;
    end
    ph = PhGap;
    enter_step();
  endfunction

  function automatic void ms_tick();
    step_t st;
    if (!en_q || ph == PhIdle) return;
    if (ms_left != 0) ms_left = ms_left - 9'd1;
    if (ms_left != 0) return;
    if (ph == PhTone) begin
      st = tone_step(cur_seq, cur_idx[2:0]);
      // A zero gap moves on to the next step within the same tick.
      if (st.gap != 0) begin
        ph = PhGap;
        ms_left = st.gap;
      end else begin
        advance_step();
      end
    end else begin
      advance_step();
    end
  endfunction

  function automatic void start_seq(input logic [2:0] code);
    logic [3:0] n;
    n = seq_steps(code);
    if (!en_q || n == 0) return;
    if (n > MaxSteps) n = 4'(MaxSteps);
    halt_playback();
    cur_seq = code;
    cur_cnt = n;
    cur_idx = '0;
    ph = PhTone;
    enter_step();
  endfunction

  // Apply one item to the predictor and return the tone state after it.
  function automatic out_item_t sequencer_next(input in_item_t it);
    out_item_t r;
    logic      acc;
    step_t     st;
    acc = 1'b0;
    case (it.command)
      CmdTick: ms_tick();
      CmdPlay: begin
        if (it.request_code < NumSeqs) begin
          acc = 1'b1;
          start_seq(it.request_code);
        end
      end
      CmdStop: halt_playback();
      default: ;
    endcase
    st = tone_step(cur_seq, cur_idx[2:0]);
    r.tone_on          = (ph == PhTone);
    r.tone_frequency   = (ph == PhTone) ? st.freq : 12'd0;
    r.request_accepted = acc;
    r.playing          = (ph != PhIdle);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: every handshake is sampled at the rising edge with pre-edge
  // values. The expectation is queued before the result check so that a
  // result can never race its own prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) en_q = cfg_data_i;
      if (in_valid_i && in_ready_o) expected_tones.push_back(sequencer_next(in_data_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_tones.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_tones.pop_front();
          if (out_data_o.tone_on !== want.tone_on)
            report_mismatch($sformatf("tone_on got %0b want %0b",
                                      out_data_o.tone_on, want.tone_on));
          if (out_data_o.tone_frequency !== want.tone_frequency)
            report_mismatch($sformatf("tone_frequency got %0d want %0d",
                                      out_data_o.tone_frequency, want.tone_frequency));
          if (out_data_o.request_accepted !== want.request_accepted)
            report_mismatch($sformatf("request_accepted got %0b want %0b",
                                      out_data_o.request_accepted, want.request_accepted));
          if (out_data_o.playing !== want.playing)
            report_mismatch($sformatf("playing got %0b want %0b",
                                      out_data_o.playing, want.playing));
        end
      end
    end
  end

  // Receiver: backpressure drawn fresh every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. Each returns right after the edge that completed its
  // transfer; send_item leaves valid high so back-to-back items need no toggle.
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_item(input logic [1:0] cmd, input logic [2:0] code);
    in_item_t it;
    it.command = cmd;
    it.request_code = code;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_tick();
    send_item(mk_item(CmdTick, 3'($urandom_range(0, ReqCodeMax))));
  endtask

  // Hold off the sender until every owed result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_tones.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic en);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic reset_dut();
    reset_model();
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command, code extremes, invalid codes, restart while playing,
  // requests while disabled and the frozen state while disabled.
  task automatic test_directed();
    // Out of reset the block is disabled: play is acknowledged but inert.
    send_item(mk_item(CmdPlay, ReqButton));
    send_tick();
    send_item(mk_item(CmdPlay, ReqCodeMax));
    send_item(mk_item(CmdStop, ReqButton));
    send_item(mk_item(CmdNone, ReqCodeMax));
    write_enable(1'b1);
    send_item(mk_item(CmdPlay, ReqButton));
    send_tick();
    send_item(mk_item(CmdNone, ReqButton));
    send_item(mk_item(CmdPlay, 3'(NumSeqs)));
    // Restart on top of a running sequence.
    send_item(mk_item(CmdPlay, ReqVictory));
    send_tick();
    send_item(mk_item(CmdPlay, ReqDot));
    send_item(mk_item(CmdPlay, ReqSolenoid));
    send_tick();
    send_item(mk_item(CmdPlay, ReqDash));
    send_tick();
    // Disabled mid-tone: state freezes and keeps being reported.
    write_enable(1'b0);
    send_tick();
    send_item(mk_item(CmdPlay, ReqVictory));
    send_item(mk_item(CmdPlay, ReqCodeMax - 3'd1));
    write_enable(1'b1);
    send_tick();
    send_item(mk_item(CmdStop, ReqCodeMax));
    send_tick();
    send_item(mk_item(CmdPlay, ReqCodeMax));
    send_item(mk_item(CmdStop, ReqButton));
  endtask

  // The short sequences played to their natural end, covering the tone
  // that ends with a zero gap and the return to idle. Longer sequences are
  // walked through their first steps and gaps by the random episodes.
  task automatic test_full_playback();
    int span;
    write_enable(1'b1);
    for (int code = 0; code < NumSeqs; code++) begin
      span = seq_total_ms(3'(code));
      if (span <= FullPlayMaxMs) begin
        send_item(mk_item(CmdPlay, 3'(code)));
        repeat (span + 2) send_tick();
      end
    end
  endtask

  // Random episodes: mostly a play followed by a run of ticks that either
  // reaches the end or gets cut short, salted with noise items, stray
  // stops and restarts, and disabled stretches.
  task automatic test_random(input int n_items);
    int       sent;
    int       pick;
    int       span;
    int       ticks;
    logic [2:0] code;
    sent = 0;
    write_enable(1'b1);
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(mk_item(2'($urandom_range(0, CmdNone)), 3'($urandom_range(0, ReqCodeMax))));
        sent++;
      end else if (pick < 12) begin
        // Disabled stretch: drains first, so the sender also stalls here.
        write_enable(1'b0);
        repeat ($urandom_range(1, 6)) begin
          send_item(mk_item(2'($urandom_range(0, CmdNone)),
                            3'($urandom_range(0, ReqCodeMax))));
          sent++;
        end
        write_enable(1'b1);
      end else begin
        if ($urandom_range(0, 4) == 0) code = 3'($urandom_range(NumSeqs, ReqCodeMax));
        else code = 3'($urandom_range(0, NumSeqs - 1));
        span = seq_total_ms(code);
        if (span == 0) span = 20;
        if ($urandom_range(0, 2) == 0) ticks = span + $urandom_range(0, 3);
        else ticks = $urandom_range(0, span);
        // Long sequences are cut to a run that still crosses a step boundary.
        if (ticks > TickCap) ticks = $urandom_range(TickCap / 2, TickCap);
        send_item(mk_item(CmdPlay, code));
        sent++;
        for (int t = 0; t < ticks; t++) begin
          case ($urandom_range(0, 299))
            0: send_item(mk_item(CmdStop, 3'($urandom_range(0, ReqCodeMax))));
            1: send_item(mk_item(CmdPlay, 3'($urandom_range(0, ReqCodeMax))));
            2: send_item(mk_item(CmdNone, 3'($urandom_range(0, ReqCodeMax))));
            default: send_tick();
          endcase
          sent++;
        end
      end
    end
  endtask

  initial begin
    mismatches = 0;
    set_idling(0, 0);
    reset_dut();
    set_idling(16, 83);
    test_directed();
    test_full_playback();
    test_random(250);
    set_idling(83, 16);
    test_random(250);
    set_idling(0, 0);
    test_random(250);
    drain();
    repeat (4) @(posedge clk_i);
    if (expected_tones.size() != 0) report_mismatch("results still owed at end of run");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
